[rtl/core/ogr_pkg.sv]
// Shared types, widths and constants of the onset beat accuracy grader.
`default_nettype none

package ogr_pkg;

  // Longest block before it is closed without an end mark.
  localparam int unsigned MaxBlock = 4096;

  localparam int unsigned CountW  = $clog2(MaxBlock + 1);
  localparam int unsigned SampleW = 16;
  localparam int unsigned SqW     = 31;
  localparam int unsigned ThrW    = 15;
  localparam int unsigned RateW   = 18;
  localparam int unsigned OffsetW = 12;
  localparam int unsigned FrameW  = 48;
  localparam int unsigned EnergyW = SqW - 1 + CountW;
  localparam int unsigned ProdW   = 2 * ThrW + CountW;
  localparam int unsigned DiffW   = 32;
  localparam int unsigned CfgW    = RateW;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);

  localparam logic [DiffW-1:0] DiffMax = {1'b0, {(DiffW - 1){1'b1}}};
  localparam logic [DiffW-1:0] DiffMin = {1'b1, {(DiffW - 1){1'b0}}};

  // Configuration register indexes.
  localparam logic CfgSampleRate = 1'b0;
  localparam logic CfgThreshold  = 1'b1;

  localparam logic [RateW-1:0] SampleRateReset = RateW'(44100);
  localparam logic [ThrW-1:0]  ThresholdReset  = ThrW'(3277);

  typedef enum logic [1:0] {
    GradePerfect = 2'd0,
    GradeEarly   = 2'd1,
    GradeLate    = 2'd2
  } grade_e;

  typedef enum logic [1:0] {
    OpBeat   = 2'd0,
    OpSample = 2'd1,
    OpClose  = 2'd2
  } op_kind_e;

  typedef struct packed {
    logic                      cmd;
    logic signed [SampleW-1:0] sample;
    logic                      block_end;
    logic [OffsetW-1:0]        beat_offset;
  } in_item_t;

  typedef struct packed {
    grade_e                  grade;
    logic signed [DiffW-1:0] diff_frames;
  } out_item_t;

  // Classified operation handed from the front to the back.
  typedef struct packed {
    op_kind_e           kind;
    logic [SqW-1:0]     sq;
    logic [CountW-1:0]  count;
    logic [OffsetW-1:0] beat_offset;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

[rtl/core/ogr_front.sv]
// Front end: accepts items, squares samples, counts the block and classifies.
`default_nettype none

module ogr_front
  import ogr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  output logic          full_o,
  input  wire in_item_t in_i,
  input  wire q_stat_t  q_stat_i,
  output logic          q_push_o,
  output op_t           q_op_o
);

  logic              valid_q, valid_d;
  op_t               op_q, op_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] count_inc;
  logic              close;
  logic              accept;
  logic signed [2*SampleW-1:0] square;

  assign full_o   = valid_q && q_stat_i.full;
  assign accept   = push_i && !full_o;
  assign q_push_o = valid_q && !q_stat_i.full;
  assign q_op_o   = op_q;

  assign square    = in_i.sample * in_i.sample;
  assign count_inc = count_q + CountW'(1);
  assign close     = in_i.block_end || (count_inc >= CountW'(MaxBlock));

  always_comb begin
    valid_d = valid_q;
    op_d    = op_q;
    count_d = count_q;
    if (q_push_o) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d          = 1'b1;
      op_d.sq          = square[SqW-1:0];
      op_d.count       = count_inc;
      op_d.beat_offset = in_i.beat_offset;
      if (in_i.cmd) begin
        op_d.kind = OpBeat;
      end else if (close) begin
        op_d.kind = OpClose;
        count_d   = '0;
      end else begin
        op_d.kind = OpSample;
        count_d   = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

endmodule

`default_nettype wire

[rtl/core/ogr_queue.sv]
// Short queue of classified operations between the front and the back.
`default_nettype none

module ogr_queue
  import ogr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  op_i,
  input  wire logic pop_i,
  output q_stat_t   stat_o,
  output op_t       op_o
);

  op_t              mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == (QPtrW + 1)'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign op_o         = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (QPtrW + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (QPtrW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= op_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ogr_back.sv]
// Back end: energy and frame bookkeeping, onset decision, grading and result queue.
`default_nettype none

module ogr_back
  import ogr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire q_stat_t          q_stat_i,
  input  wire op_t              q_op_i,
  output logic                  q_pop_o,
  input  wire logic [RateW-1:0] sample_rate_i,
  input  wire logic [ThrW-1:0]  threshold_i,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output out_item_t             out_o
);

  // Threshold squared, refreshed every cycle from the register.
  logic [2*ThrW-1:0] thr2_q;

  // Block bookkeeping.
  logic [EnergyW-1:0] energy_q;
  logic [FrameW-1:0]  frame_q, beat_q, hit_q;

  // Decision stage, loaded by a block close.
  logic               b_valid_q;
  logic [EnergyW-1:0] b_energy_q;
  logic [ProdW-1:0]   b_prod_q;
  logic [FrameW-1:0]  b_start_q;
  logic [FrameW:0]    b_diff_q;

  // Result queue of two entries.
  out_item_t  res_q [2];
  logic       res_wr_q, res_rd_q;
  logic [1:0] res_cnt_q;
  logic       res_full, res_pop;

  logic              advance, pop_op, loud, apart, perfect, hit_raw, fire;
  logic [FrameW-1:0] since;
  logic [18:0]       since_x10;
  logic [FrameW:0]   mag;
  logic [20:0]       mag_x200, rate_x3;
  logic [FrameW:DiffW-1] diff_top;
  out_item_t         result;

  // Onset test: block energy against threshold squared times the sample count.
  assign loud = b_energy_q > b_prod_q;

  // Debounce: ten times the distance must exceed the sample rate. A distance of
  // 2^15 frames or more passes for any rate the register can hold.
  assign since     = b_start_q - hit_q;
  assign since_x10 = (19'(since[14:0]) << 3) + (19'(since[14:0]) << 1);
  assign apart     = (since[FrameW-1:15] != '0) || (since_x10 > 19'(sample_rate_i));

  assign hit_raw = loud && apart;
  assign advance = !(b_valid_q && hit_raw && res_full);
  assign fire    = b_valid_q && hit_raw && !res_full;
  assign pop_op  = advance && !q_stat_i.empty;
  assign q_pop_o = pop_op;

  // Perfect window: 200 times the distance below three times the sample rate.
  assign mag      = b_diff_q[FrameW] ? (~b_diff_q + (FrameW + 1)'(1)) : b_diff_q;
  assign mag_x200 = (21'(mag[12:0]) << 7) + (21'(mag[12:0]) << 6) + (21'(mag[12:0]) << 3);
  assign rate_x3  = 21'(sample_rate_i) + (21'(sample_rate_i) << 1);
  assign perfect  = (mag[FrameW:13] == '0) && (mag_x200 < rate_x3);
  assign diff_top = b_diff_q[FrameW:DiffW-1];

  always_comb begin
    priority if (perfect) begin
      result.grade = GradePerfect;
    end else if (b_diff_q[FrameW]) begin
      result.grade = GradeEarly;
    end else begin
      result.grade = GradeLate;
    end
    priority if ((diff_top == '0) || (diff_top == '1)) begin
      result.diff_frames = b_diff_q[DiffW-1:0];
    end else if (b_diff_q[FrameW]) begin
      result.diff_frames = DiffMin;
    end else begin
      result.diff_frames = DiffMax;
    end
  end

  always_ff @(posedge clk_i) begin
    thr2_q <= threshold_i * threshold_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q  <= '0;
      frame_q   <= '0;
      beat_q    <= '0;
      hit_q     <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        hit_q <= b_start_q;
      end
      if (advance) begin
        b_valid_q <= pop_op && (q_op_i.kind == OpClose);
      end
      if (pop_op) begin
        unique case (q_op_i.kind)
          OpBeat: begin
            beat_q <= frame_q + FrameW'(q_op_i.beat_offset);
          end
          OpSample: begin
            energy_q <= energy_q + EnergyW'(q_op_i.sq);
          end
          OpClose: begin
            energy_q <= '0;
            frame_q  <= frame_q + FrameW'(q_op_i.count);
          end
          default: begin
            energy_q <= energy_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_op && (q_op_i.kind == OpClose)) begin
      b_energy_q <= energy_q + EnergyW'(q_op_i.sq);
      b_prod_q   <= thr2_q * q_op_i.count;
      b_start_q  <= frame_q;
      b_diff_q   <= {1'b0, frame_q} - {1'b0, beat_q};
    end
  end

  assign res_full = (res_cnt_q == 2'd2);
  assign empty_o  = (res_cnt_q == 2'd0);
  assign res_pop  = pop_i && !empty_o;
  assign out_o    = res_q[res_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (fire) begin
        res_wr_q <= ~res_wr_q;
      end
      if (res_pop) begin
        res_rd_q <= ~res_rd_q;
      end
      if (fire && !res_pop) begin
        res_cnt_q <= res_cnt_q + 2'd1;
      end else if (res_pop && !fire) begin
        res_cnt_q <= res_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q[res_wr_q] <= result;
    end
  end

endmodule

`default_nettype wire

[rtl/core/onset_beat_accuracy_grader.sv]
// Top level of the onset beat accuracy grader: configuration registers and wiring.
// Throughput is one item per cycle while the operation queue has room; it backs up when the
// result queue is full and a detected onset waits. A block-closing sample with an onset
// passes the front register, the operation queue, the decision stage and the result queue.
// Reset is asynchronous and active low; it clears counters, frame state and queues
// and loads the register defaults, with no clearing pass afterwards.
`default_nettype none

module onset_beat_accuracy_grader
  import ogr_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire in_item_t        in_i,
  output logic                 empty,
  input  wire logic            pop,
  output out_item_t            out_o,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i
);

  logic [RateW-1:0] sample_rate_q;
  logic [ThrW-1:0]  threshold_q;
  q_stat_t          q_stat;
  logic             q_push, q_pop;
  op_t              q_op_in, q_op_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q <= SampleRateReset;
      threshold_q   <= ThresholdReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSampleRate: sample_rate_q <= cfg_wdata_i[RateW-1:0];
        CfgThreshold:  threshold_q   <= cfg_wdata_i[ThrW-1:0];
      endcase
    end
  end

  ogr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .q_push_o (q_push),
    .q_op_o   (q_op_in)
  );

  ogr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .op_i   (q_op_in),
    .pop_i  (q_pop),
    .stat_o (q_stat),
    .op_o   (q_op_out)
  );

  ogr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .q_op_i        (q_op_out),
    .q_pop_o       (q_pop),
    .sample_rate_i (sample_rate_q),
    .threshold_i   (threshold_q),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_o         (out_o)
  );

  // A perfect grade implies a distance small enough to need no saturation.
  a_perfect_small : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_o.grade == GradePerfect)) |->
      ((out_o.diff_frames[DiffW-1:13] == '0) || (out_o.diff_frames[DiffW-1:13] == '1)))
    else $error("perfect grade with a large distance");

  a_early_neg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_o.grade == GradeEarly)) |-> out_o.diff_frames[DiffW-1])
    else $error("early grade with a non-negative distance");

  a_late_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_o.grade == GradeLate)) |-> !out_o.diff_frames[DiffW-1])
    else $error("late grade with a negative distance");

  a_queue_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("operation queue both full and empty");

endmodule

`default_nettype wire
